// File: design/assert_macros.svh
// Assertion macros used by mpbo_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/mpbo_pkg.sv
// ----------------------------------------------------------------------------
// mpbo_pkg
// Shared constants, types and tables of the MD5 body pad block.
// ----------------------------------------------------------------------------
package mpbo_pkg;

  localparam int KEY_MAX_BYTES = 32;
  localparam int CHUNK_BYTES   = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_hdr;    // latch header, clear chaining
    logic init_md5;    // load message block and MD5 state
    logic round;       // run one MD5 round
    logic finish;      // add state, store pad chunk
    logic emit;        // form the result word
    logic [5:0] rnd;   // round number
  } mpbo_cmd_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

// File: design/mpbo_ctrl.sv
// ----------------------------------------------------------------------------
// mpbo_ctrl
// Sequencer: accepts a word, runs 64 MD5 rounds when a new pad chunk is
// due, then presents the result word.
// ----------------------------------------------------------------------------
module mpbo_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_sop,
  input  logic                 out_stall,
  input  logic [3:0]           pos,
  output logic                 in_stall,
  output logic                 out_valid,
  output mpbo_pkg::mpbo_cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_ROUND, S_FIN, S_OUT} state_t;

  state_t     state_r, state_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic       acc;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign acc       = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    rnd_nxt      = rnd_r;
    cmd          = '0;
    cmd.rnd      = rnd_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.load_hdr = in_sop;
          if (in_sop || pos == 4'd0) begin
            cmd.init_md5 = 1'b1;
            rnd_nxt      = 6'd0;
            state_nxt    = S_ROUND;
          end else begin
            cmd.emit  = 1'b1;
            state_nxt = S_OUT;
          end
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rnd_r   <= 6'd0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

`include "assert_macros.svh"
  `ASSERT_IMP(a_no_accept_busy, clk, rst_n, out_valid, in_stall, "accept while busy")
  `ASSERT_NEXT(a_round_wrap, clk, rst_n, state_r == S_ROUND && rnd_r == 6'd63,
               state_r == S_FIN, "round counter did not end in finish")
  `ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && out_stall, out_valid,
               "result dropped under stall")

endmodule

// File: design/mpbo_dp.sv
// ----------------------------------------------------------------------------
// mpbo_dp
// Datapath: key and header registers, message block, one MD5 round per
// cycle, pad chunk store and the output XOR.
// ----------------------------------------------------------------------------
module mpbo_dp #(
  parameter int KEY_MAX_BYTES = mpbo_pkg::KEY_MAX_BYTES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_write_enable,
  input  logic [mpbo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mpbo_pkg::CFG_DATA_W-1:0]   cfg_write_data,
  input  logic [7:0]                        in_body_byte,
  input  logic [31:0]                       in_session_number,
  input  logic [7:0]                        in_header_version,
  input  logic [7:0]                        in_sequence_number,
  input  mpbo_pkg::mpbo_cmd_t               cmd,
  output logic [3:0]                        pos,
  output logic [7:0]                        out_result_byte
);

  logic [255:0] key_r;
  logic [5:0]   klen_r;
  logic [5:0]   klen;
  logic [31:0]  sess_r;
  logic [7:0]   ver_r, seq_r;
  logic         chained_r;
  logic [127:0] pad_r;
  logic [3:0]   pos_r;
  logic [7:0]   byte_r;
  logic [7:0]   res_r;
  logic [511:0] blk_r;
  logic [31:0]  a_r, b_r, c_r, d_r;

  logic [31:0]  sess_n;
  logic [7:0]   ver_n, seq_n;
  logic         chain_n;
  logic [7:0]   msg [64];
  logic [511:0] blk_n;
  logic [6:0]   mlen;
  logic [15:0]  bits;
  logic [31:0]  f, t, rot, mw;
  logic [3:0]   g;
  logic [5:0]   r;
  logic [127:0] dig;
  logic [31:0]  h0, h1, h2, h3;

  assign pos  = pos_r;
  assign klen = (klen_r > 6'(KEY_MAX_BYTES)) ? 6'(KEY_MAX_BYTES) : klen_r;
  assign r    = cmd.rnd;

  // Header view seen by the chunk about to start.
  assign sess_n  = cmd.load_hdr ? in_session_number : sess_r;
  assign ver_n   = cmd.load_hdr ? in_header_version : ver_r;
  assign seq_n   = cmd.load_hdr ? in_sequence_number : seq_r;
  assign chain_n = cmd.load_hdr ? 1'b0 : chained_r;

  // Message byte j is picked by its own position, one mux per byte.
  always_comb begin
    mlen = 7'd6 + 7'(klen) + (chain_n ? 7'd16 : 7'd0);
    bits = {6'd0, mlen, 3'd0};
    for (int j = 0; j < 64; j++) begin
      if (j < 4) begin
        msg[j] = sess_n[31-8*j -: 8];
      end else if (7'(j) < 7'd4 + 7'(klen)) begin
        msg[j] = key_r[255-8*(j-4) -: 8];
      end else if (7'(j) == 7'd4 + 7'(klen)) begin
        msg[j] = ver_n;
      end else if (7'(j) == 7'd5 + 7'(klen)) begin
        msg[j] = seq_n;
      end else if (7'(j) < mlen) begin
        msg[j] = pad_r[127-8*(j-6-int'(klen)) -: 8];
      end else if (7'(j) == mlen) begin
        msg[j] = 8'h80;
      end else if (j == 56) begin
        msg[j] = bits[7:0];
      end else if (j == 57) begin
        msg[j] = bits[15:8];
      end else begin
        msg[j] = 8'h00;
      end
    end
    for (int w = 0; w < 16; w++) begin
      blk_n[32*w +: 32] = {msg[4*w+3], msg[4*w+2], msg[4*w+1], msg[4*w]};
    end
  end

  always_comb begin
    case (r[5:4])
      2'd0: begin f = (b_r & c_r) | (~b_r & d_r); g = r[3:0]; end
      2'd1: begin f = (d_r & b_r) | (~d_r & c_r); g = 4'(5*int'(r) + 1); end
      2'd2: begin f = b_r ^ c_r ^ d_r; g = 4'(3*int'(r) + 5); end
      default: begin f = c_r ^ (b_r | ~d_r); g = 4'(7*int'(r)); end
    endcase
    mw  = blk_r[32*g +: 32];
    t   = a_r + f + mpbo_pkg::md5_k(r) + mw;
    rot = (t << mpbo_pkg::md5_rot(r)) | (t >> (6'd32 - {1'b0, mpbo_pkg::md5_rot(r)}));
    h0  = a_r + 32'h67452301;
    h1  = b_r + 32'hefcdab89;
    h2  = c_r + 32'h98badcfe;
    h3  = d_r + 32'h10325476;
    // Digest bytes come out of each word low byte first.
    for (int i = 0; i < 4; i++) begin
      dig[127-8*i -: 8]  = h0[8*i +: 8];
      dig[95-8*i -: 8]   = h1[8*i +: 8];
      dig[63-8*i -: 8]   = h2[8*i +: 8];
      dig[31-8*i -: 8]   = h3[8*i +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= '0;
      klen_r    <= '0;
      sess_r    <= '0;
      ver_r     <= '0;
      seq_r     <= '0;
      chained_r <= 1'b0;
      pad_r     <= '0;
      pos_r     <= '0;
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          mpbo_pkg::REG_KEY0:    key_r[255:192] <= cfg_write_data;
          mpbo_pkg::REG_KEY1:    key_r[191:128] <= cfg_write_data;
          mpbo_pkg::REG_KEY2:    key_r[127:64]  <= cfg_write_data;
          mpbo_pkg::REG_KEY3:    key_r[63:0]    <= cfg_write_data;
          mpbo_pkg::REG_KEY_LEN: klen_r         <= cfg_write_data[5:0];
          default: ;
        endcase
      end
      if (cmd.load_hdr) begin
        sess_r    <= in_session_number;
        ver_r     <= in_header_version;
        seq_r     <= in_sequence_number;
        chained_r <= 1'b0;
        pos_r     <= 4'd0;
      end
      if (cmd.finish) begin
        pad_r     <= dig;
        chained_r <= 1'b1;
      end
      if (cmd.emit) begin
        pos_r <= pos_r + 4'd1;
      end
      if (cmd.finish) begin
        pos_r <= pos_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_md5 || cmd.emit) begin
      byte_r <= in_body_byte;
    end
    if (cmd.init_md5) begin
      blk_r <= blk_n;
      a_r   <= 32'h67452301;
      b_r   <= 32'hefcdab89;
      c_r   <= 32'h98badcfe;
      d_r   <= 32'h10325476;
    end else if (cmd.round) begin
      a_r <= d_r;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= b_r + rot;
    end
    if (cmd.emit) begin
      res_r <= in_body_byte ^ pad_r[127-8*pos_r -: 8];
    end else if (cmd.finish) begin
      res_r <= byte_r ^ dig[127 -: 8];
    end
  end

  assign out_result_byte = res_r;

endmodule

// File: design/md5_pad_body_obfuscator.sv
// ----------------------------------------------------------------------------
// md5_pad_body_obfuscator
// Streams body bytes and XORs each with an MD5 derived pad byte.
// ----------------------------------------------------------------------------
//   channel  direction  handshake
//   in_      input      in_valid / in_stall
//   out_     output     out_valid / out_stall
//   cfg_     input      cfg_write_enable, no wait
//
// A word whose pad chunk is on hand goes from accept straight into the result register.
// Every 16th word of a packet, and each packet start, first runs the shared
// MD5 round unit through its rounds and then a finish step.
// One word is in flight at a time; input is stalled until the result leaves.
// Synchronous reset clears key, header, chaining and position to zero.
module md5_pad_body_obfuscator #(
  parameter int KEY_MAX_BYTES = mpbo_pkg::KEY_MAX_BYTES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_write_enable,
  input  logic [mpbo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpbo_pkg::CFG_DATA_W-1:0]  cfg_write_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_body_byte,
  input  logic                             in_start_of_packet,
  input  logic [31:0]                      in_session_number,
  input  logic [7:0]                       in_header_version,
  input  logic [7:0]                       in_sequence_number,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_result_byte
);

  mpbo_pkg::mpbo_cmd_t cmd;
  logic [3:0]          pos;

  mpbo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_sop    (in_start_of_packet),
    .out_stall (out_stall),
    .pos       (pos),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  mpbo_dp #(.KEY_MAX_BYTES(KEY_MAX_BYTES)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write_enable   (cfg_write_enable),
    .cfg_index          (cfg_index),
    .cfg_write_data     (cfg_write_data),
    .in_body_byte       (in_body_byte),
    .in_session_number  (in_session_number),
    .in_header_version  (in_header_version),
    .in_sequence_number (in_sequence_number),
    .cmd                (cmd),
    .pos                (pos),
    .out_result_byte    (out_result_byte)
  );

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 body pad obfuscator testbench
// Drives body words through the block under several key settings and idle
// patterns, predicts each result byte with a local MD5 pad generator and
// compares it with what the block returns.
// ----------------------------------------------------------------------------
module testbench;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_write_enable = 1'b0;
  logic [mpbo_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mpbo_pkg::CFG_DATA_W-1:0] cfg_write_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_body_byte = '0;
  logic        in_start_of_packet = 1'b0;
  logic [31:0] in_session_number = '0;
  logic [7:0]  in_header_version = '0;
  logic [7:0]  in_sequence_number = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_result_byte;

  md5_pad_body_obfuscator u_top (.*);

  always #6 clk = ~clk;

  // Predictor state.
  logic [63:0]  key_word [4];
  logic [5:0]   key_len;
  logic [127:0] pad_chunk;
  logic [3:0]   pad_pos;
  logic         pad_chained;
  logic [31:0]  hdr_session;
  logic [7:0]   hdr_version;
  logic [7:0]   hdr_sequence;

  logic [7:0] expected_bytes [$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int failures = 0;

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int MD5_S [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  // MD5 of a message of at most 55 bytes; digest byte 0 lands in bits 127:120.
  function automatic logic [127:0] md5_short(input logic [7:0] msg [64], input int len);
    logic [7:0]  blk [64];
    logic [31:0] m [16];
    logic [31:0] h [4];
    logic [31:0] a, b, c, d, f, t;
    logic [127:0] dig;
    int g, s;
    for (int i = 0; i < 64; i++) blk[i] = (i < len) ? msg[i] : 8'h00;
    blk[len] = 8'h80;
    blk[56] = 8'(len * 8);
    blk[57] = 8'((len * 8) >> 8);
    for (int i = 0; i < 16; i++) m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    h = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
    a = h[0]; b = h[1]; c = h[2]; d = h[3];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin f = (b & c) | (~b & d); g = i; end
      else if (i < 32) begin f = (d & b) | (~d & c); g = (5*i + 1) % 16; end
      else if (i < 48) begin f = b ^ c ^ d; g = (3*i + 5) % 16; end
      else begin f = c ^ (b | ~d); g = (7*i) % 16; end
      s = MD5_S[((i / 16) * 4) + (i % 4)];
      t = a + f + MD5_K[i] + m[g];
      a = d; d = c; c = b;
      b = b + ((t << s) | (t >> (32 - s)));
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d;
    for (int i = 0; i < 16; i++) dig[127 - 8*i -: 8] = 8'(h[i/4] >> (8 * (i % 4)));
    return dig;
  endfunction

  function automatic logic [7:0] obfuscate_byte(input logic [7:0] body, input logic sop,
                                                input logic [31:0] sess, input logic [7:0] ver,
                                                input logic [7:0] seq);
    logic [7:0] msg [64];
    int n, klen;
    logic [7:0] res;
    if (sop) begin
      hdr_session = sess; hdr_version = ver; hdr_sequence = seq;
      pad_chained = 1'b0; pad_pos = 4'd0;
    end
    if (pad_pos == 4'd0) begin
      klen = (key_len > mpbo_pkg::KEY_MAX_BYTES) ? mpbo_pkg::KEY_MAX_BYTES : int'(key_len);
      n = 0;
      for (int i = 0; i < 4; i++) begin msg[n] = hdr_session[31 - 8*i -: 8]; n++; end
      for (int i = 0; i < klen; i++) begin
        msg[n] = key_word[i/8][63 - 8*(i%8) -: 8]; n++;
      end
      msg[n] = hdr_version; n++;
      msg[n] = hdr_sequence; n++;
      if (pad_chained)
        for (int i = 0; i < mpbo_pkg::CHUNK_BYTES; i++) begin
          msg[n] = pad_chunk[127 - 8*i -: 8]; n++;
        end
      for (int i = n; i < 64; i++) msg[i] = 8'h00;
      pad_chunk = md5_short(msg, n);
      pad_chained = 1'b1;
    end
    res = body ^ pad_chunk[127 - 8*pad_pos -: 8];
    pad_pos = pad_pos + 4'd1;
    return res;
  endfunction

  task automatic write_reg(input logic [mpbo_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_write_data <= data;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    if (idx <= mpbo_pkg::REG_KEY3) key_word[idx[1:0]] = data;
    else if (idx == mpbo_pkg::REG_KEY_LEN) key_len = data[5:0];
  endtask

  // Valid stays up after a word is taken; the next word replaces it, an idle gap or a drain lowers it.
  task automatic send_word(input logic [7:0] body, input logic sop, input logic [31:0] sess,
                           input logic [7:0] ver, input logic [7:0] seq);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_body_byte <= body;
    in_start_of_packet <= sop;
    in_session_number <= sess;
    in_header_version <= ver;
    in_sequence_number <= seq;
    do @(posedge clk); while (in_stall);
    expected_bytes.push_back(obfuscate_byte(body, sop, sess, ver, seq));
    @(negedge clk);
  endtask

  always @(negedge clk) out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected result word 0x%02h", out_result_byte);
        failures++;
      end else begin
        if (out_result_byte !== expected_bytes[0]) begin
          $error("result_byte expected 0x%02h actual 0x%02h", expected_bytes[0], out_result_byte);
          failures++;
        end
        void'(expected_bytes.pop_front());
      end
    end
  end

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic send_packet(input int len);
    logic [31:0] sess;
    logic [7:0] ver, seq;
    sess = $urandom; ver = 8'($urandom); seq = 8'($urandom);
    for (int i = 0; i < len; i++) send_word(8'($urandom), i == 0, sess, ver, seq);
  endtask

  task automatic load_key(input int len);
    write_reg(mpbo_pkg::REG_KEY0, {$urandom, $urandom});
    write_reg(mpbo_pkg::REG_KEY1, {$urandom, $urandom});
    write_reg(mpbo_pkg::REG_KEY2, {$urandom, $urandom});
    write_reg(mpbo_pkg::REG_KEY3, {$urandom, $urandom});
    write_reg(mpbo_pkg::REG_KEY_LEN, 64'(len));
  endtask

  // Words before any packet start use the all-zero reset header.
  task automatic test_no_header;
    for (int i = 0; i < 3; i++) send_word(8'($urandom), 1'b0, '1, '1, '1);
    drain();
  endtask

  task automatic test_directed;
    write_reg(mpbo_pkg::REG_KEY0, '1); write_reg(mpbo_pkg::REG_KEY1, '0);
    write_reg(mpbo_pkg::REG_KEY2, 64'h0000_ff00_0000_00ff); write_reg(mpbo_pkg::REG_KEY3, '1);
    write_reg(mpbo_pkg::REG_KEY_LEN, 64'd32);
    send_word(8'h00, 1'b1, 32'hffff_ffff, 8'hff, 8'hff);
    send_word(8'hff, 1'b0, 32'h0, 8'h0, 8'h0);
    send_word(8'h5a, 1'b1, 32'h0, 8'h00, 8'h00);
    for (int i = 0; i < 17; i++) send_word(8'(i * 37), 1'b0, 32'h0, 8'h0, 8'h0);
    drain();
    // Lengths beyond the limit saturate; length zero uses no key bytes.
    write_reg(mpbo_pkg::REG_KEY_LEN, 64'd63);
    send_packet(2);
    drain();
    write_reg(mpbo_pkg::REG_KEY_LEN, 64'd0);
    send_packet(2);
    drain();
    // An index past the last register must be ignored.
    @(negedge clk);
    cfg_write_enable <= 1'b1; cfg_index <= '1; cfg_write_data <= '1;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    send_packet(2);
    drain();
  endtask

  task automatic test_random(input int idle, input int stall, input int words);
    int sent;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    load_key($urandom_range(32));
    sent = 0;
    while (sent < words) begin
      int len;
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 34) : $urandom_range(20, 1);
      if ($urandom_range(5) == 0) begin
        // A stray continuation word without a fresh start.
        send_word(8'($urandom), 1'b0, $urandom, 8'($urandom), 8'($urandom));
        sent++;
      end
      send_packet(len);
      sent += len;
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
  endtask

  initial begin
    key_word = '{default: '0};
    key_len = '0; pad_chunk = '0; pad_pos = '0; pad_chained = 1'b0;
    hdr_session = '0; hdr_version = '0; hdr_sequence = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_no_header();
    test_directed();
    test_random(0, 0, 100);
    test_random(62, 0, 100);
    test_random(0, 62, 100);
    test_random(23, 23, 100);
    if (failures == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #40ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
